// ----- rtl/eks_pkg.sv -----
// Shared types and constants for the encoder knob setpoint block.
package eks_pkg;

    localparam int MaxDetents = 4;
    localparam int DetW = 3;

    localparam logic [2:0] CFG_VLIM  = 3'd0;
    localparam logic [2:0] CFG_VSTEP = 3'd1;
    localparam logic [2:0] CFG_CLIM  = 3'd2;
    localparam logic [2:0] CFG_CSTEP = 3'd3;
    localparam logic [2:0] CFG_CFLR  = 3'd4;
    localparam logic [2:0] CFG_CPD   = 3'd5;
    localparam logic [2:0] CFG_DEB   = 3'd6;
    localparam logic [2:0] CFG_SPAN  = 3'd7;

    localparam logic [1:0] OUTCOME_NONE = 2'd0;
    localparam logic [1:0] OUTCOME_OK   = 2'd1;
    localparam logic [1:0] OUTCOME_REJ  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture item, do delta, outcome
        logic resid;    // add delta to residual
        logic detent;   // try one detent
        logic finish;   // clamp backlog, debounce, result to output
    } eks_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more;     // residual holds a whole detent
    } eks_stat_t;

endpackage

// ----- rtl/encoder_knob_setpoint_ui.sv -----
// Top level of the encoder knob and button setpoint front end.
// One UI tick is taken per input transfer and gives one result transfer. A tick runs
// load, residual, one step per detent applied (0 to 4) and finish; the detent
// loop steps one detent a cycle through a single setpoint adder and clamp. The result
// register frees once taken; the next tick is accepted after this result is loaded.
// The user makes configuration writes only while idle; the block does not enforce it.
module encoder_knob_setpoint_ui (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] position,
    input  logic        position_error,
    input  logic        button_level,
    input  logic        fault_active,
    input  logic        fault_resettable,
    input  logic        reset_in_progress,
    input  logic        feedback_ok,
    input  logic [15:0] voltage_now,
    input  logic [15:0] current_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] voltage_next,
    output logic [15:0] current_next,
    output logic        voltage_written,
    output logic        current_written,
    output logic        ui_mode,
    output logic        fault_reset_request,
    output logic [1:0]  fault_reset_outcome,
    output logic [2:0]  clockwise_detents,
    output logic [2:0]  counterclockwise_detents,
    output logic [2:0]  rejected_steps,
    output logic [1:0]  invalid_events,
    output logic signed [31:0] position_delta
);
    import eks_pkg::*;

    eks_cmd_t cmd;
    eks_stat_t stat;
    logic out_busy;

    eks_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(in_valid && in_ready),
        .out_busy(out_busy),
        .stat(stat),
        .in_ready(in_ready),
        .cmd(cmd)
    );

    eks_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .position(position), .position_error(position_error),
        .button_level(button_level), .fault_active(fault_active),
        .fault_resettable(fault_resettable), .reset_in_progress(reset_in_progress),
        .feedback_ok(feedback_ok), .voltage_now(voltage_now), .current_now(current_now),
        .out_ready(out_ready), .out_valid(out_valid),
        .voltage_next(voltage_next), .current_next(current_next),
        .voltage_written(voltage_written), .current_written(current_written),
        .ui_mode(ui_mode), .fault_reset_request(fault_reset_request),
        .fault_reset_outcome(fault_reset_outcome),
        .clockwise_detents(clockwise_detents),
        .counterclockwise_detents(counterclockwise_detents),
        .rejected_steps(rejected_steps), .invalid_events(invalid_events),
        .position_delta(position_delta), .out_busy(out_busy)
    );
endmodule

// ----- rtl/eks_ctrl.sv -----
// Sequencer for the per-tick detent loop and handshakes.
module eks_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  eks_pkg::eks_stat_t stat,
    output logic              in_ready,
    output eks_pkg::eks_cmd_t  cmd
);
    import eks_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RES  = 2'd1;
    localparam logic [1:0] S_DET  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [DetW-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                cmd.resid = 1'b1;
                cnt_next = '0;
                state_next = S_DET;
            end
            S_DET:
            begin
                if (stat.more && cnt_reg != DetW'(MaxDetents))
                begin
                    cmd.detent = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ----- rtl/eks_dp.sv -----
// Datapath: position wrap, residual, setpoint stepping, debounce, result register.
module eks_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  eks_pkg::eks_cmd_t  cmd,
    output eks_pkg::eks_stat_t stat,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_idx,
    input  logic [31:0]       cfg_data,
    input  logic [31:0]       position,
    input  logic              position_error,
    input  logic              button_level,
    input  logic              fault_active,
    input  logic              fault_resettable,
    input  logic              reset_in_progress,
    input  logic              feedback_ok,
    input  logic [15:0]       voltage_now,
    input  logic [15:0]       current_now,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [15:0]       voltage_next,
    output logic [15:0]       current_next,
    output logic              voltage_written,
    output logic              current_written,
    output logic              ui_mode,
    output logic              fault_reset_request,
    output logic [1:0]        fault_reset_outcome,
    output logic [2:0]        clockwise_detents,
    output logic [2:0]        counterclockwise_detents,
    output logic [2:0]        rejected_steps,
    output logic [1:0]        invalid_events,
    output logic signed [31:0] position_delta,
    output logic              out_busy
);
    import eks_pkg::*;

    logic [15:0] vlim_reg, vstep_reg, clim_reg, cstep_reg, cflr_reg;
    logic [7:0] cpd_reg, deb_reg;
    logic [31:0] span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlim_reg <= 16'd30000;
            vstep_reg <= 16'd100;
            clim_reg <= 16'd5000;
            cstep_reg <= 16'd10;
            cflr_reg <= 16'd0;
            cpd_reg <= 8'd4;
            deb_reg <= 8'd5;
            span_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_VLIM:  vlim_reg <= cfg_data[15:0];
                CFG_VSTEP: vstep_reg <= cfg_data[15:0];
                CFG_CLIM:  clim_reg <= cfg_data[15:0];
                CFG_CSTEP: cstep_reg <= cfg_data[15:0];
                CFG_CFLR:  cflr_reg <= cfg_data[15:0];
                CFG_CPD:   cpd_reg <= cfg_data[7:0];
                CFG_DEB:   deb_reg <= cfg_data[7:0];
                CFG_SPAN:  span_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // persistent state
    logic [31:0] prev_reg;
    logic loaded_reg;
    logic signed [8:0] resid_reg;
    logic held_reg, mode_reg, pend_reg;
    logic [7:0] dcnt_reg;

    // per-tick working registers
    logic signed [33:0] delta_reg;
    logic signed [34:0] racc_reg;   // wide residual during the loop
    logic [15:0] v_reg, c_reg;
    logic vw_reg, cw_reg;
    logic [2:0] ncw_reg, nccw_reg, nrej_reg;
    logic allow_reg, err_reg, btn_reg, fl_reg, fr_reg;
    logic [1:0] outc_reg;

    // wrap of the position difference
    logic signed [33:0] raw_d, half_s, span_s, wrap_d;
    always_comb
    begin
        raw_d = $signed({2'b00, position}) - $signed({2'b00, prev_reg});
        span_s = $signed({2'b00, span_reg});
        half_s = $signed({3'b000, span_reg[31:1]});
        if (!loaded_reg)
            wrap_d = '0;
        else if (raw_d > half_s)
            wrap_d = raw_d - span_s;
        else if (raw_d < -half_s)
            wrap_d = raw_d + span_s;
        else
            wrap_d = raw_d;
    end

    logic signed [34:0] cpd_s;
    logic up_ok, dn_ok;
    assign cpd_s = $signed({27'd0, cpd_reg});
    assign up_ok = (racc_reg >= cpd_s);
    assign dn_ok = (racc_reg <= -cpd_s);
    assign stat.more = (cpd_reg != 8'd0) && (up_ok || dn_ok);

    // one setpoint step
    logic [16:0] vcur, ccur, cmn, vnx, cnx;
    logic [15:0] stepped;
    logic changed;
    always_comb
    begin
        vcur = (v_reg > vlim_reg) ? {1'b0, vlim_reg} : {1'b0, v_reg};
        cmn = (v_reg != 16'd0) ? {1'b0, cflr_reg} : 17'd0;
        ccur = (c_reg > clim_reg) ? {1'b0, clim_reg} : {1'b0, c_reg};
        if (ccur < cmn)
            ccur = cmn;
        if (up_ok)
        begin
            vnx = ({1'b0, vstep_reg} > {1'b0, vlim_reg} - vcur) ? {1'b0, vlim_reg}
                  : vcur + {1'b0, vstep_reg};
            // floor above limit: ccur > lim, compare signed-wise
            cnx = ($signed({1'b0, cstep_reg}) > $signed({1'b0, clim_reg}) - $signed(ccur))
                  ? {1'b0, clim_reg} : ccur + {1'b0, cstep_reg};
        end
        else
        begin
            vnx = (vcur < {1'b0, vstep_reg}) ? 17'd0 : vcur - {1'b0, vstep_reg};
            cnx = ($signed({1'b0, cstep_reg}) > $signed(ccur) - $signed(cmn))
                  ? cmn : ccur - {1'b0, cstep_reg};
        end
        stepped = mode_reg ? cnx[15:0] : vnx[15:0];
        changed = mode_reg ? (cnx[15:0] != c_reg) : (vnx[15:0] != v_reg);
    end

    // backlog clamp and debounce
    logic signed [8:0] resid_fin;
    logic clamp_inv;
    logic held_n, mode_n, pend_n, req_n;
    logic [7:0] dcnt_n, dinc;
    logic [1:0] inv_fin;
    always_comb
    begin
        clamp_inv = 1'b0;
        resid_fin = racc_reg[8:0];
        if (cpd_reg == 8'd0)
            resid_fin = '0;
        else if (up_ok)
        begin
            resid_fin = 9'(cpd_reg) - 9'sd1;
            clamp_inv = 1'b1;
        end
        else if (dn_ok)
        begin
            resid_fin = 9'sd1 - 9'(cpd_reg);
            clamp_inv = 1'b1;
        end
        inv_fin = 2'({1'b0, err_reg} + {1'b0, cpd_reg == 8'd0} + {1'b0, clamp_inv});

        held_n = held_reg;
        mode_n = mode_reg;
        pend_n = pend_reg;
        req_n = 1'b0;
        dinc = (dcnt_reg < deb_reg) ? dcnt_reg + 8'd1 : dcnt_reg;
        dcnt_n = dcnt_reg;
        if (btn_reg == held_reg)
        begin
            // level differs from held state (held=0 waits for 0 level)
            dcnt_n = dinc;
            if (dinc >= deb_reg)
            begin
                held_n = ~held_reg;
                dcnt_n = '0;
                if (!held_reg)
                begin
                    if (fl_reg && fr_reg)
                    begin
                        req_n = 1'b1;
                        pend_n = 1'b1;
                    end
                    else
                    begin
                        mode_n = ~mode_reg;
                    end
                end
            end
        end
        else
        begin
            dcnt_n = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            delta_reg <= wrap_d;
            v_reg <= voltage_now;
            c_reg <= current_now;
            vw_reg <= 1'b0;
            cw_reg <= 1'b0;
            ncw_reg <= '0;
            nccw_reg <= '0;
            nrej_reg <= '0;
            allow_reg <= !fault_active && feedback_ok;
            err_reg <= position_error;
            btn_reg <= button_level;
            fl_reg <= fault_active;
            fr_reg <= fault_resettable;
            if (pend_reg && !fault_active)
                outc_reg <= OUTCOME_OK;
            else if (pend_reg && !reset_in_progress)
                outc_reg <= OUTCOME_REJ;
            else
                outc_reg <= OUTCOME_NONE;
        end
        if (cmd.resid)
            racc_reg <= 35'(resid_reg) + 35'(delta_reg);
        if (cmd.detent)
        begin
            if (up_ok)
            begin
                racc_reg <= racc_reg - cpd_s;
                ncw_reg <= ncw_reg + 3'd1;
            end
            else
            begin
                racc_reg <= racc_reg + cpd_s;
                nccw_reg <= nccw_reg + 3'd1;
            end
            if (!allow_reg || !changed)
                nrej_reg <= nrej_reg + 3'd1;
            else if (mode_reg)
            begin
                c_reg <= stepped;
                cw_reg <= 1'b1;
            end
            else
            begin
                v_reg <= stepped;
                vw_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            voltage_next <= v_reg;
            current_next <= c_reg;
            voltage_written <= vw_reg;
            current_written <= cw_reg;
            ui_mode <= mode_n;
            fault_reset_request <= req_n;
            fault_reset_outcome <= outc_reg;
            clockwise_detents <= ncw_reg;
            counterclockwise_detents <= nccw_reg;
            rejected_steps <= nrej_reg;
            invalid_events <= inv_fin;
            position_delta <= delta_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            loaded_reg <= 1'b0;
            resid_reg <= '0;
            held_reg <= 1'b0;
            mode_reg <= 1'b0;
            pend_reg <= 1'b0;
            dcnt_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_reg <= position;
                loaded_reg <= 1'b1;
                if (pend_reg && (!fault_active || !reset_in_progress))
                    pend_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                resid_reg <= resid_fin;
                held_reg <= held_n;
                mode_reg <= mode_n;
                dcnt_reg <= dcnt_n;
                if (req_n)
                    pend_reg <= pend_n;
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign out_busy = out_valid && !out_ready;
endmodule

// ----- rtl/eks_checker.sv -----
// Port-level checks for the encoder knob setpoint block, bound to the top level.
module eks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  fault_reset_outcome,
    input logic [2:0]  clockwise_detents,
    input logic [2:0]  counterclockwise_detents,
    input logic [2:0]  rejected_steps,
    input logic [15:0] voltage_next
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(voltage_next))
        else $error("result dropped while stalled");
    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> clockwise_detents == 3'd0 || counterclockwise_detents == 3'd0)
        else $error("detents in both directions");
    a_rej_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rejected_steps <= clockwise_detents + counterclockwise_detents)
        else $error("more rejects than detents");
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fault_reset_outcome != 2'd3)
        else $error("bad outcome code");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken during a tick");
endmodule

bind encoder_knob_setpoint_ui eks_checker u_eks_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .fault_reset_outcome(fault_reset_outcome),
    .clockwise_detents(clockwise_detents),
    .counterclockwise_detents(counterclockwise_detents),
    .rejected_steps(rejected_steps), .voltage_next(voltage_next)
);

// ----- tb/encoder_knob_setpoint_ui_tb.sv -----
// Self-checking testbench for the encoder knob and button setpoint front end.
`timescale 1ns / 100ps

module encoder_knob_setpoint_ui_tb;
    import eks_pkg::*;

    typedef struct packed {
        logic [15:0] voltage_next;
        logic [15:0] current_next;
        logic        voltage_written;
        logic        current_written;
        logic        ui_mode;
        logic        fault_reset_request;
        logic [1:0]  fault_reset_outcome;
        logic [2:0]  clockwise_detents;
        logic [2:0]  counterclockwise_detents;
        logic [2:0]  rejected_steps;
        logic [1:0]  invalid_events;
        logic [31:0] position_delta;
    } knob_result_t;

    typedef struct packed {
        logic [31:0] position;
        logic        position_error;
        logic        button_level;
        logic        fault_active;
        logic        fault_resettable;
        logic        reset_in_progress;
        logic        feedback_ok;
        logic [15:0] voltage_now;
        logic [15:0] current_now;
    } knob_tick_t;

    class knob_scoreboard;
        longint unsigned vlim, vstep, clim, cstep, cfloor, cpd, deb, span;
        logic [31:0] prev_pos;
        bit          loaded;
        longint      residual;
        bit          held, mode, pending;
        int          deb_count;
        knob_result_t expected_q[$];
        int errors;
        int checked;

        function void reset_state();
            vlim = 30000; vstep = 100; clim = 5000; cstep = 10;
            cfloor = 0; cpd = 4; deb = 5; span = 65536;
            prev_pos = 0; loaded = 0; residual = 0;
            held = 0; mode = 0; pending = 0; deb_count = 0;
            expected_q.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_VLIM:  vlim = val[15:0];
                CFG_VSTEP: vstep = val[15:0];
                CFG_CLIM:  clim = val[15:0];
                CFG_CSTEP: cstep = val[15:0];
                CFG_CFLR:  cfloor = val[15:0];
                CFG_CPD:   cpd = val[7:0];
                CFG_DEB:   deb = val[7:0];
                default:   span = val;
            endcase
        endfunction

        function void note_tick(knob_tick_t t);
            knob_result_t r;
            longint d, half, cur, nx, mn, rr;
            int ncw, nccw, nrej, inv;
            bit allowed, up;
            logic [15:0] v, c;
            r = '0;
            ncw = 0; nccw = 0; nrej = 0; inv = 0; d = 0;
            v = t.voltage_now;
            c = t.current_now;
            allowed = !t.fault_active && t.feedback_ok;
            r.fault_reset_outcome = OUTCOME_NONE;
            if (pending)
            begin
                if (!t.fault_active)
                begin
                    r.fault_reset_outcome = OUTCOME_OK;
                    pending = 0;
                end
                else if (!t.reset_in_progress)
                begin
                    r.fault_reset_outcome = OUTCOME_REJ;
                    pending = 0;
                end
            end
            if (loaded)
            begin
                half = span / 2;
                d = longint'(t.position) - longint'(prev_pos);
                if (d > half) d -= span;
                else if (d < -half) d += span;
            end
            loaded = 1;
            prev_pos = t.position;
            if (t.position_error) inv++;
            if (cpd == 0)
            begin
                residual = 0;
                inv++;
            end
            else
            begin
                rr = residual + d;
                for (int i = 0; i < MaxDetents; i++)
                begin
                    if (rr >= longint'(cpd))
                    begin
                        rr -= cpd;
                        up = 1;
                    end
                    else if (rr <= -longint'(cpd))
                    begin
                        rr += cpd;
                        up = 0;
                    end
                    else break;
                    if (up) ncw++; else nccw++;
                    if (!allowed) nrej++;
                    else if (!mode)
                    begin
                        cur = v;
                        if (cur > vlim) cur = vlim;
                        if (up) nx = (vstep > vlim - cur) ? vlim : cur + vstep;
                        else nx = (cur < vstep) ? 0 : cur - vstep;
                        if (nx == v) nrej++;
                        else
                        begin
                            v = nx[15:0];
                            r.voltage_written = 1;
                        end
                    end
                    else
                    begin
                        cur = c;
                        mn = (v > 0) ? cfloor : 0;
                        if (cur > clim) cur = clim;
                        if (cur < mn) cur = mn;
                        // floor above limit leaves cur over the limit: compare signed
                        if (up) nx = (longint'(cstep) > longint'(clim) - cur) ? clim : cur + cstep;
                        else nx = (cstep > cur - mn) ? mn : cur - cstep;
                        if (nx == c) nrej++;
                        else
                        begin
                            c = nx[15:0];
                            r.current_written = 1;
                        end
                    end
                end
                if (rr >= longint'(cpd))
                begin
                    rr = cpd - 1;
                    inv++;
                end
                else if (rr <= -longint'(cpd))
                begin
                    rr = 1 - longint'(cpd);
                    inv++;
                end
                residual = rr;
            end
            if (held == t.button_level)
            begin
                // level differs from the held state: count toward a change
                if (deb_count < deb) deb_count++;
                if (deb_count >= deb)
                begin
                    deb_count = 0;
                    if (!held)
                    begin
                        if (t.fault_active && t.fault_resettable)
                        begin
                            r.fault_reset_request = 1;
                            pending = 1;
                        end
                        else mode = !mode;
                    end
                    held = !held;
                end
            end
            else deb_count = 0;
            r.voltage_next = v;
            r.current_next = c;
            r.ui_mode = mode;
            r.clockwise_detents = ncw[2:0];
            r.counterclockwise_detents = nccw[2:0];
            r.rejected_steps = nrej[2:0];
            r.invalid_events = inv[1:0];
            r.position_delta = d[31:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(knob_result_t a);
            knob_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (a.voltage_next !== e.voltage_next)
            begin
                $error("voltage_next exp %0d got %0d", e.voltage_next, a.voltage_next); errors++;
            end
            if (a.current_next !== e.current_next)
            begin
                $error("current_next exp %0d got %0d", e.current_next, a.current_next); errors++;
            end
            if (a.voltage_written !== e.voltage_written)
            begin
                $error("voltage_written exp %0d got %0d", e.voltage_written, a.voltage_written);
                errors++;
            end
            if (a.current_written !== e.current_written)
            begin
                $error("current_written exp %0d got %0d", e.current_written, a.current_written);
                errors++;
            end
            if (a.ui_mode !== e.ui_mode)
            begin
                $error("ui_mode exp %0d got %0d", e.ui_mode, a.ui_mode); errors++;
            end
            if (a.fault_reset_request !== e.fault_reset_request)
            begin
                $error("fault_reset_request exp %0d got %0d",
                       e.fault_reset_request, a.fault_reset_request);
                errors++;
            end
            if (a.fault_reset_outcome !== e.fault_reset_outcome)
            begin
                $error("fault_reset_outcome exp %0d got %0d",
                       e.fault_reset_outcome, a.fault_reset_outcome);
                errors++;
            end
            if (a.clockwise_detents !== e.clockwise_detents)
            begin
                $error("clockwise_detents exp %0d got %0d",
                       e.clockwise_detents, a.clockwise_detents);
                errors++;
            end
            if (a.counterclockwise_detents !== e.counterclockwise_detents)
            begin
                $error("counterclockwise_detents exp %0d got %0d",
                       e.counterclockwise_detents, a.counterclockwise_detents);
                errors++;
            end
            if (a.rejected_steps !== e.rejected_steps)
            begin
                $error("rejected_steps exp %0d got %0d", e.rejected_steps, a.rejected_steps);
                errors++;
            end
            if (a.invalid_events !== e.invalid_events)
            begin
                $error("invalid_events exp %0d got %0d", e.invalid_events, a.invalid_events);
                errors++;
            end
            if (a.position_delta !== e.position_delta)
            begin
                $error("position_delta exp %0d got %0d",
                       $signed(e.position_delta), $signed(a.position_delta));
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    knob_tick_t  tick;
    logic        out_valid;
    logic        out_ready;
    knob_result_t res;

    knob_scoreboard sb;
    int  cycles;
    bit  no_idle;
    int  sent;
    logic [31:0] pos_now;

    encoder_knob_setpoint_ui dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .position(tick.position), .position_error(tick.position_error),
        .button_level(tick.button_level), .fault_active(tick.fault_active),
        .fault_resettable(tick.fault_resettable),
        .reset_in_progress(tick.reset_in_progress), .feedback_ok(tick.feedback_ok),
        .voltage_now(tick.voltage_now), .current_now(tick.current_now),
        .out_valid(out_valid), .out_ready(out_ready),
        .voltage_next(res.voltage_next), .current_next(res.current_next),
        .voltage_written(res.voltage_written), .current_written(res.current_written),
        .ui_mode(res.ui_mode), .fault_reset_request(res.fault_reset_request),
        .fault_reset_outcome(res.fault_reset_outcome),
        .clockwise_detents(res.clockwise_detents),
        .counterclockwise_detents(res.counterclockwise_detents),
        .rejected_steps(res.rejected_steps), .invalid_events(res.invalid_events),
        .position_delta(res.position_delta)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check at the rising edge, throttle ready at the falling one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(res);
    end

    always @(negedge clk)
    begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // called at a falling edge; drop valid and wait for every result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer,
    // with valid still high so the next call can follow without a gap
    task automatic send_tick(knob_tick_t t);
        if (!no_idle)
            while ($urandom_range(0, 99) < 28)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        tick <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(t);
        sent++;
        @(negedge clk);
    endtask

    function automatic knob_tick_t rand_tick(bit wild);
        knob_tick_t t;
        t = '0;
        if (wild || $urandom_range(0, 19) == 0)
            pos_now = $urandom();
        else
            pos_now = pos_now + 32'($signed($urandom_range(0, 40)) - 20);
        t.position = pos_now;
        t.position_error = ($urandom_range(0, 15) == 0);
        t.button_level = ($urandom_range(0, 99) < 50) ? 1'($urandom_range(0, 1))
                                                       : tick.button_level;
        t.fault_active = ($urandom_range(0, 3) == 0);
        t.fault_resettable = 1'($urandom_range(0, 1));
        t.reset_in_progress = 1'($urandom_range(0, 1));
        t.feedback_ok = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
            0: t.voltage_now = 16'($urandom());
            1: t.voltage_now = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            default: t.voltage_now = 16'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 3))
            0: t.current_now = 16'($urandom());
            1: t.current_now = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            default: t.current_now = 16'($urandom_range(0, 300));
        endcase
        return t;
    endfunction

    task automatic random_cfg(int phase);
        write_cfg(CFG_VLIM,  (phase == 1) ? 32'hFFFF : $urandom_range(0, 2000));
        write_cfg(CFG_VSTEP, (phase == 1) ? 32'hFFFF : $urandom_range(0, 300));
        write_cfg(CFG_CLIM,  (phase == 1) ? 32'h0    : $urandom_range(0, 400));
        write_cfg(CFG_CSTEP, (phase == 1) ? 32'h0    : $urandom_range(0, 50));
        write_cfg(CFG_CFLR,  (phase == 2) ? 32'hFFFF : $urandom_range(0, 500));
        write_cfg(CFG_CPD,   (phase == 1) ? 32'hFF   : $urandom_range(0, 6));
        write_cfg(CFG_DEB,   (phase == 2) ? 32'hFF   : $urandom_range(0, 3));
        write_cfg(CFG_SPAN,  (phase == 1) ? 32'h8000_0000 :
                             (phase == 2) ? 32'h2 :
                             (phase == 3) ? 32'hFFFF_FFFF : $urandom_range(2, 4096));
    endtask

    initial
    begin
        knob_tick_t t;
        sb = new();
        sb.reset_state();
        cycles = 0;
        sent = 0;
        no_idle = 0;
        pos_now = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VLIM;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        tick = '0;
        tick.button_level = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: default setup, turns, button presses, faults, extremes
        t = '0;
        t.button_level = 1; t.feedback_ok = 1; t.voltage_now = 1000; t.current_now = 100;
        t.position = 32'hFFFF_FFFF;
        send_tick(t);
        t.position = 32'hFFFF_FFFF + 8; send_tick(t);
        t.position = t.position + 40; send_tick(t);
        t.position = t.position - 40; t.voltage_now = 16'hFFFF; send_tick(t);
        t.voltage_now = 0; t.position = t.position - 4; send_tick(t);
        t.position_error = 1; t.fault_active = 1; t.position = t.position + 4;
        send_tick(t);
        t.position_error = 0; t.fault_active = 0;
        t.button_level = 0;
        repeat (6) send_tick(t);
        t.button_level = 1;
        repeat (6) send_tick(t);
        t.current_now = 16'hFFFF; t.voltage_now = 16'hFFFF; t.position = t.position + 8;
        send_tick(t);
        // press while a resettable fault is held, then the outcome ticks
        t.fault_active = 1; t.fault_resettable = 1; t.button_level = 0;
        drain();
        write_cfg(CFG_DEB, 0);
        send_tick(t);
        t.reset_in_progress = 1; send_tick(t);
        t.reset_in_progress = 0; t.button_level = 1; send_tick(t);
        drain();

        // random phases; phase 0 runs with no idling on either side
        for (int phase = 0; phase < 8; phase++)
        begin
            random_cfg(phase % 5);
            no_idle = (phase == 0);
            for (int n = 0; n < 180; n++)
                send_tick(rand_tick(phase == 3 && n % 3 == 0));
            drain();
        end
        no_idle = 0;

        $display("Covered %0d ticks over several register settings, %0d results checked.",
                 sent, sb.checked);
        $display("Span, detent size and debounce extremes included.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- encoder_knob_setpoint_ui.f -----
rtl/eks_pkg.sv
rtl/eks_ctrl.sv
rtl/eks_dp.sv
rtl/encoder_knob_setpoint_ui.sv
rtl/eks_checker.sv
tb/encoder_knob_setpoint_ui_tb.sv
